// File: design/timing_wheel_scheduler_unit_defines.svh
// Assertion macros for the timing wheel scheduler.
`ifndef TIMING_WHEEL_SCHEDULER_UNIT_DEFINES_SVH
`define TIMING_WHEEL_SCHEDULER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TWS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tws: check failed");
`define TWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tws: sequence check failed");
`else
`define TWS_ASSERT(lbl, clk, rst_n, prop)
`define TWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/tws_pkg.sv
// Types and constants of the timing wheel scheduler.
`default_nettype none
package tws_pkg;
  localparam int SLOTS_DEF    = 32;
  localparam int CAPACITY_DEF = 256;
  localparam int OBJECTS_DEF  = 256;
  localparam logic [15:0] SLICE_RESET = 16'd100;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_KILL   = 2'd3;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_NONE      = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_NO_REMOVE = 3'd5;
  localparam logic [2:0] ST_KILLED    = 3'd6;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         object_id;
    logic signed [15:0] time_to_move;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         ready_object;
    logic signed [15:0] ready_time;
    logic [31:0]        elapsed_time_out;
  } out_res_t;
endpackage
`default_nettype wire

// File: design/tws_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module tws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/timing_wheel_scheduler_unit.sv
// Top level of the timing wheel scheduler: sequencer around the slot and pool memories.
//  channel | ports                          | handshake
//  request | start, busy, in_req            | taken when start & !busy
//  result  | out_valid, out_res             | one-cycle strobe, no back-pressure
//  config  | cfg_we, cfg_wdata              | written when cfg_we
// Add answers with a full status when the pool is full; kill and remove need no placement.
// Get scans the slot memory slot by slot, drops entries of dead objects and places
// live ones again via the quotient unit until an entry's time has gone negative.
// After reset a clearing pass over max(SLOTS, OBJECTS) addresses holds busy high.
// A result is shown the cycle busy falls; a new request may be taken in that cycle.
`default_nettype none
`include "timing_wheel_scheduler_unit_defines.svh"
module timing_wheel_scheduler_unit #(
  parameter int SLOTS    = tws_pkg::SLOTS_DEF,
  parameter int CAPACITY = tws_pkg::CAPACITY_DEF,
  parameter int OBJECTS  = tws_pkg::OBJECTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire tws_pkg::in_req_t in_req,
  output logic                  out_valid,
  output tws_pkg::out_res_t     out_res,
  input  wire logic             cfg_we,
  input  wire logic [15:0]      cfg_wdata
);
  localparam int SW    = $clog2(SLOTS);
  localparam int AW    = $clog2(CAPACITY);
  localparam int PW    = $clog2(CAPACITY + 1);
  localparam int OW    = $clog2(OBJECTS);
  localparam int CAPW  = 16 + SW;
  localparam int CLR_N = (SLOTS > OBJECTS) ? SLOTS : OBJECTS;
  localparam int CW    = $clog2(CLR_N);
  localparam int SWW   = $clog2(SLOTS + 2);
  localparam logic [PW-1:0] NIL = PW'(CAPACITY);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_A_FREE, S_P_MUL, S_P_DIV, S_P_FIN, S_P_SLOT,
    S_G_RD, S_G_CHK, S_G_ENT, S_G_DEC, S_R_CHK, S_R_LNK, S_KILL
  } state_t;

  state_t              state_r;
  logic [CW-1:0]       clr_r;
  logic [15:0]         slice_r;
  logic [SW-1:0]       pos_r;
  logic [31:0]         elapsed_r;
  logic [PW-1:0]       free_head_r;
  logic [PW-1:0]       fresh_r;
  logic [SWW-1:0]      sweeps_r;
  logic [1:0]          op_r;
  logic [7:0]          id_r;
  logic [AW-1:0]       e_r;
  logic [7:0]          obj_r;
  logic signed [15:0]  t_r;
  logic [PW-1:0]       next_r;
  logic [PW-1:0]       last_r;
  logic [CAPW-1:0]     cap_r;
  logic [15:0]         rem_r;
  logic [SW-1:0]       q_r;
  logic [SW-1:0]       k_r;
  logic                out_valid_r;
  tws_pkg::out_res_t   out_r;

  logic [15:0]         s_eff;
  logic [31:0]         el_adv;
  logic [2*PW-1:0]     sl_rdata, sl_wdata;
  logic                sl_we;
  logic [SW-1:0]       sl_waddr, sl_raddr;
  logic [PW-1:0]       sl_first, sl_last;
  logic [PW-1:0]       lk_rdata, lk_wdata;
  logic                lk_we;
  logic [AW-1:0]       lk_waddr, lk_raddr;
  logic [23:0]         dt_rdata;
  logic                dt_we;
  logic [OW-1:0]       al_waddr, al_raddr;
  logic                al_we, al_wdata, al_rdata;
  logic [CAPW-1:0]     div_d;
  logic                div_hit;
  logic                t_ge_cap;
  logic [SW-1:0]       shift;
  logic signed [17:0]  nt18;
  logic signed [15:0]  nt;
  logic [SW:0]         idx_sum;
  logic [SW-1:0]       idx;

  function automatic logic [OW-1:0] obj_index(input logic [7:0] v);
    int r;
    r = int'(v);
    for (int k = 7; k >= 0; k--) begin
      if (r >= (OBJECTS << k)) begin
        r = r - (OBJECTS << k);
      end
    end
    return OW'(r);
  endfunction

  assign s_eff  = (slice_r == 16'd0) ? 16'd1 : slice_r;
  assign el_adv = elapsed_r + 32'(s_eff);
  assign sl_first = sl_rdata[2*PW-1:PW];
  assign sl_last  = sl_rdata[PW-1:0];

  // placement arithmetic
  assign div_d   = CAPW'(s_eff) << k_r;
  assign div_hit = CAPW'(rem_r) >= div_d;
  assign t_ge_cap = !t_r[15] && (CAPW'(unsigned'(t_r)) >= cap_r);

  always_comb begin
    shift = '0;
    nt18  = 18'(t_r);
    if (t_ge_cap) begin
      shift = SW'(SLOTS - 1);
      nt18  = 18'(t_r) - 18'(cap_r[15:0]);
    end else if (!t_r[15]) begin
      shift = q_r + SW'(1);
      nt18  = $signed({2'b00, rem_r}) - $signed({2'b00, s_eff});
    end else if (($signed(18'(t_r)) + $signed({2'b00, s_eff})) > 18'sd0) begin
      shift = SW'(1);
      nt18  = $signed(18'(t_r)) - $signed({2'b00, s_eff});
    end
    if (nt18 < -18'sd32768) begin
      nt = 16'sh8000;
    end else if (nt18 > 18'sd32767) begin
      nt = 16'sh7fff;
    end else begin
      nt = nt18[15:0];
    end
    idx_sum = {1'b0, pos_r} + {1'b0, shift};
    if (idx_sum >= (SW+1)'(SLOTS)) begin
      idx_sum = idx_sum - (SW+1)'(SLOTS);
    end
    idx = idx_sum[SW-1:0];
  end

  // memory ports
  always_comb begin
    sl_raddr = (state_r == S_P_FIN) ? idx : pos_r;
    sl_we    = 1'b0;
    sl_waddr = pos_r;
    sl_wdata = {NIL, NIL};
    lk_raddr = (state_r == S_IDLE) ? free_head_r[AW-1:0] : sl_first[AW-1:0];
    lk_we    = 1'b0;
    lk_waddr = e_r;
    lk_wdata = free_head_r;
    dt_we    = 1'b0;
    al_raddr = obj_index(dt_rdata[23:16]);
    al_we    = 1'b0;
    al_waddr = obj_index(id_r);
    al_wdata = 1'b0;
    unique case (state_r)
      S_CLR: begin
        sl_we    = CW'(clr_r) < CW'(SLOTS) || SLOTS >= CLR_N;
        sl_waddr = SW'(clr_r);
        al_we    = CW'(clr_r) < CW'(OBJECTS) || OBJECTS >= CLR_N;
        al_waddr = OW'(clr_r);
      end
      S_A_FREE: begin
        al_we    = (free_head_r != NIL) || (fresh_r != NIL);
        al_wdata = 1'b1;
      end
      S_P_FIN: begin
        dt_we    = 1'b1;
        lk_we    = 1'b1;
        lk_wdata = NIL;
      end
      S_P_SLOT: begin
        sl_we    = 1'b1;
        sl_waddr = idx;
        if (sl_first == NIL) begin
          sl_wdata = {PW'(e_r), PW'(e_r)};
        end else begin
          sl_wdata = {sl_first, PW'(e_r)};
          lk_we    = 1'b1;
          lk_waddr = sl_last[AW-1:0];
          lk_wdata = PW'(e_r);
        end
      end
      S_G_DEC: begin
        if (!al_rdata || !t_r[15]) begin
          sl_we    = 1'b1;
          sl_wdata = (next_r == NIL) ? {NIL, NIL} : {next_r, last_r};
          lk_we    = !al_rdata;
        end
      end
      S_R_LNK: begin
        sl_we    = 1'b1;
        sl_wdata = (lk_rdata == NIL) ? {NIL, NIL} : {lk_rdata, last_r};
        lk_we    = 1'b1;
      end
      S_KILL: begin
        al_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tws_ram #(.WIDTH(2*PW), .DEPTH(SLOTS)) u_slot_ram (
    .clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
    .raddr(sl_raddr), .rdata(sl_rdata)
  );
  tws_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_link_ram (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(lk_raddr), .rdata(lk_rdata)
  );
  tws_ram #(.WIDTH(24), .DEPTH(CAPACITY)) u_entry_ram (
    .clk(clk), .we(dt_we), .waddr(e_r), .wdata({obj_r, nt}),
    .raddr(sl_first[AW-1:0]), .rdata(dt_rdata)
  );
  tws_ram #(.WIDTH(1), .DEPTH(OBJECTS)) u_alive_ram (
    .clk(clk), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
    .raddr(al_raddr), .rdata(al_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      slice_r     <= tws_pkg::SLICE_RESET;
      pos_r       <= '0;
      elapsed_r   <= '0;
      free_head_r <= NIL;
      fresh_r     <= '0;
      sweeps_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        slice_r <= cfg_wdata;
      end
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + CW'(1);
          if (clr_r == CW'(CLR_N - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_r     <= in_req.opcode;
            id_r     <= in_req.object_id;
            obj_r    <= in_req.object_id;
            t_r      <= in_req.time_to_move;
            sweeps_r <= '0;
            unique case (in_req.opcode)
              tws_pkg::OP_ADD:    state_r <= S_A_FREE;
              tws_pkg::OP_GET:    state_r <= S_G_CHK;
              tws_pkg::OP_REMOVE: state_r <= S_R_CHK;
              default:            state_r <= S_KILL;
            endcase
          end
        end
        S_A_FREE: begin
          if (free_head_r != NIL) begin
            e_r         <= free_head_r[AW-1:0];
            free_head_r <= lk_rdata;
            state_r     <= S_P_MUL;
          end else if (fresh_r != NIL) begin
            e_r     <= fresh_r[AW-1:0];
            fresh_r <= fresh_r + PW'(1);
            state_r <= S_P_MUL;
          end else begin
            out_valid_r <= 1'b1;
            out_r       <= '{tws_pkg::ST_FULL, 8'd0, 16'sd0, elapsed_r};
            state_r     <= S_IDLE;
          end
        end
        S_P_MUL: begin
          cap_r   <= CAPW'(s_eff) * CAPW'(SLOTS - 1);
          rem_r   <= t_r[15] ? 16'd0 : unsigned'(t_r);
          q_r     <= '0;
          k_r     <= SW'(SW - 1);
          state_r <= S_P_DIV;
        end
        S_P_DIV: begin
          if (div_hit) begin
            rem_r <= rem_r - div_d[15:0];
          end
          q_r <= {q_r[SW-2+1-1:0], div_hit} ;
          k_r <= k_r - SW'(1);
          if (k_r == '0) begin
            state_r <= S_P_FIN;
          end
        end
        S_P_FIN: begin
          state_r <= S_P_SLOT;
        end
        S_P_SLOT: begin
          if (op_r == tws_pkg::OP_ADD) begin
            out_valid_r <= 1'b1;
            out_r       <= '{tws_pkg::ST_ADDED, 8'd0, 16'sd0, elapsed_r};
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_G_RD;
          end
        end
        S_G_RD: begin
          state_r <= S_G_CHK;
        end
        S_G_CHK: begin
          if (sl_first == NIL) begin
            elapsed_r <= el_adv;
            if (pos_r == SW'(SLOTS - 1)) begin
              pos_r <= '0;
              if (sweeps_r >= SWW'(SLOTS)) begin
                out_valid_r <= 1'b1;
                out_r       <= '{tws_pkg::ST_NONE, 8'd0, 16'sd0, el_adv};
                state_r     <= S_IDLE;
              end else begin
                sweeps_r <= sweeps_r + SWW'(1);
                state_r  <= S_G_RD;
              end
            end else begin
              pos_r   <= pos_r + SW'(1);
              state_r <= S_G_RD;
            end
          end else begin
            e_r     <= sl_first[AW-1:0];
            last_r  <= sl_last;
            state_r <= S_G_ENT;
          end
        end
        S_G_ENT: begin
          obj_r   <= dt_rdata[23:16];
          t_r     <= dt_rdata[15:0];
          next_r  <= lk_rdata;
          state_r <= S_G_DEC;
        end
        S_G_DEC: begin
          if (!al_rdata) begin
            free_head_r <= PW'(e_r);
            sweeps_r    <= '0;
            state_r     <= S_G_RD;
          end else if (t_r[15]) begin
            out_valid_r <= 1'b1;
            out_r       <= '{tws_pkg::ST_FOUND, obj_r, t_r, elapsed_r};
            state_r     <= S_IDLE;
          end else begin
            sweeps_r <= '0;
            state_r  <= S_P_MUL;
          end
        end
        S_R_CHK: begin
          if (sl_first == NIL) begin
            out_valid_r <= 1'b1;
            out_r       <= '{tws_pkg::ST_NO_REMOVE, 8'd0, 16'sd0, elapsed_r};
            state_r     <= S_IDLE;
          end else begin
            e_r     <= sl_first[AW-1:0];
            last_r  <= sl_last;
            state_r <= S_R_LNK;
          end
        end
        S_R_LNK: begin
          free_head_r <= PW'(e_r);
          out_valid_r <= 1'b1;
          out_r       <= '{tws_pkg::ST_REMOVED, 8'd0, 16'sd0, elapsed_r};
          state_r     <= S_IDLE;
        end
        S_KILL: begin
          out_valid_r <= 1'b1;
          out_r       <= '{tws_pkg::ST_KILLED, 8'd0, 16'sd0, elapsed_r};
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  `TWS_ASSERT(a_strobe_idle, clk, rst_n, out_valid_r |-> state_r == S_IDLE)
  `TWS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `TWS_ASSERT(a_free_range, clk, rst_n, free_head_r <= NIL && fresh_r <= NIL)
  `TWS_ASSERT(a_sweep_range, clk, rst_n, sweeps_r <= SWW'(SLOTS))
endmodule
`default_nettype wire
